### hdl/rau_pkg.sv
package rau_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_MOD   = 3'd4;
    localparam logic [2:0] OP_FLOOR = 3'd5;
    localparam logic [2:0] OP_CEIL  = 3'd6;
    localparam logic [2:0] OP_CMP   = 3'd7;

    localparam logic [1:0] ORD_LESS  = 2'd0;
    localparam logic [1:0] ORD_EQUAL = 2'd1;
    localparam logic [1:0] ORD_GREAT = 2'd2;
    localparam logic [1:0] ORD_NAN   = 2'd3;

    localparam int IN_BITS  = 136;
    localparam int OUT_BITS = 72;

    // control to the divider
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

### hdl/rau_div.sv
module rau_div #(
    parameter int W = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rau_pkg::div_ctl_t ctl,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    output rau_pkg::div_sts_t sts,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);
    import rau_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // restoring division, one quotient bit a cycle
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[W-1]} - {1'b0, d_reg};
        if (ctl.start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_no_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> busy_reg) else $error("start did not launch");

endmodule

### hdl/rational_arithmetic_unit.sv
// channel | dir | word                                                      | accept
// s_axis  | in  | tdata: opcode, left_num, left_den, left_nan, right_num,   | tvalid & tready
//         |     |        right_den, right_nan (136 bits)                    |
// m_axis  | out | tdata: res_num, res_den, res_nan, overflow, order (72)    | tvalid & tready
// tvalid follows acceptance once the multiply steps are done for compare, after one more
// divide for floor and ceil, and after the Euclid gcd and the reducing divides for add,
// sub, mul and div; mod adds one divide. a nan word answers the next cycle. four 64-bit
// products share one 16x32 multiplier (16 steps), and every divide runs on the shared
// restoring divider; a gcd can need ~90 steps. reset is synchronous and clears control
// only; s_axis_tready is low from acceptance until the result is taken.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // opcode, left_num, left_den, left_nan, right_num, right_den, right_nan
    input  logic [rau_pkg::IN_BITS-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // res_num, res_den, res_nan, overflow, order
    output logic [rau_pkg::OUT_BITS-1:0]  m_axis_tdata
);
    import rau_pkg::*;

    localparam int DW = 2 * WORD_BITS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_COMB  = 4'd2;
    localparam logic [3:0] ST_MODD  = 4'd3;
    localparam logic [3:0] ST_MODW  = 4'd4;
    localparam logic [3:0] ST_GCDD  = 4'd5;
    localparam logic [3:0] ST_GCDW  = 4'd6;
    localparam logic [3:0] ST_RN    = 4'd7;
    localparam logic [3:0] ST_RNW   = 4'd8;
    localparam logic [3:0] ST_RDW   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;
    localparam logic [3:0] ST_FLD   = 4'd11;
    localparam logic [3:0] ST_FLW   = 4'd12;

    logic [3:0]  st_reg, st_next;
    logic [2:0]  op_reg;
    logic        an_reg, bn_reg;
    logic [WORD_BITS-1:0] am_reg, ad_reg, bm_reg, bd_reg;
    logic [DW-1:0] ca_reg, cb_reg, cd_reg, cp_reg;
    logic [DW-1:0] x_reg, y_reg;
    logic        rneg_reg;
    logic [DW-1:0] rmag_reg, rden_reg, g_reg;
    logic [3:0]  mstep_reg;
    logic [DW-1:0] acc_reg;
    logic [71:0] out_reg;
    logic        vld_reg;

    // operand unpack
    logic [2:0]  in_op;
    logic [WORD_BITS-1:0] ln, ld, rn, rd;
    logic        lnan, rnan;
    assign in_op = s_axis_tdata[2:0];
    assign ln    = s_axis_tdata[3 +: WORD_BITS];
    assign ld    = s_axis_tdata[35 +: WORD_BITS];
    assign lnan  = s_axis_tdata[67];
    assign rn    = s_axis_tdata[68 +: WORD_BITS];
    assign rd    = s_axis_tdata[100 +: WORD_BITS];
    assign rnan  = s_axis_tdata[132];

    function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] v);
        mag_of = v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    logic [WORD_BITS-1:0] lm_w, ldm_w, rm_w, rdm_w;
    logic in_nan;
    assign lm_w  = mag_of(ln);
    assign ldm_w = mag_of(ld);
    assign rm_w  = mag_of(rn);
    assign rdm_w = mag_of(rd);
    always_comb begin
        in_nan = lnan || (ld == '0);
        if (in_op != OP_FLOOR && in_op != OP_CEIL)
            in_nan = in_nan || rnan || (rd == '0);
        if ((in_op == OP_DIV || in_op == OP_MOD) && rn == '0)
            in_nan = 1'b1;
    end

    // shared 16x32 half-word multiplier: 2 partial products per 64-bit product over
    // 4 steps, three products (A, B, den) and a.mag*b.mag over 16 steps
    localparam int HW = WORD_BITS / 2;
    localparam int UW = WORD_BITS - HW;
    logic [WORD_BITS-1:0] mx, my;
    logic [DW-1:0] pp;
    logic [1:0] pi;
    logic [HW-1:0] mxh;
    logic [UW-1:0] mxh2;
    logic [UW-1:0] mh;
    logic [UW+WORD_BITS-1:0] prod;
    assign pi = mstep_reg[1:0];
    always_comb begin
        unique case (mstep_reg[3:2])
            2'd0: begin mx = am_reg; my = bd_reg; end
            2'd1: begin mx = bm_reg; my = ad_reg; end
            2'd2: begin mx = ad_reg; my = bd_reg; end
            default: begin mx = am_reg; my = bm_reg; end
        endcase
        mxh  = mx[HW-1:0];
        mxh2 = mx[WORD_BITS-1:HW];
        mh   = pi[0] ? mxh2 : UW'(mxh);
        prod = mh * my;
        unique case (pi)
            2'd0: pp = DW'(prod);
            2'd1: pp = DW'(prod) << HW;
            default: pp = '0;
        endcase
    end

    // divider
    div_ctl_t dctl;
    div_sts_t dsts;
    logic [DW-1:0] dq, dr, dvd, dvs;
    rau_div #(.W(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(dctl),
        .dividend(dvd), .divisor(dvs),
        .sts(dsts), .quotient(dq), .remainder(dr)
    );

    // signed-magnitude combination
    logic          bsub;
    logic [DW-1:0] smag;
    logic          sneg;
    always_comb begin
        bsub = (op_reg == OP_SUB) ? (!bn_reg && bm_reg != '0) : bn_reg;
        if (an_reg == bsub) begin
            sneg = an_reg; smag = ca_reg + cb_reg;
        end else if (ca_reg >= cb_reg) begin
            sneg = an_reg; smag = ca_reg - cb_reg;
        end else begin
            sneg = bsub; smag = cb_reg - ca_reg;
        end
        if (smag == '0) sneg = 1'b0;
    end

    // result pack
    localparam logic [DW-1:0] HALF = DW'(1) << (WORD_BITS - 1);
    logic          ovf;
    logic [DW-1:0] tnum;
    logic [31:0]   onum;
    logic [30:0]   oden;
    logic [WORD_BITS-1:0] tw;
    always_comb begin
        ovf  = (rneg_reg ? (rmag_reg > HALF) : (rmag_reg > HALF - 1'b1))
            || (rden_reg > HALF - 1'b1);
        tnum = rneg_reg ? (~rmag_reg + 1'b1) : rmag_reg;
        tw   = tnum[WORD_BITS-1:0];
        onum = 32'(signed'(tw));
        oden = 31'(rden_reg[WORD_BITS-2:0]);
    end

    logic cmp_lt;
    logic [1:0] cmp_ord;
    always_comb begin
        cmp_lt = ca_reg < cb_reg;
        if (an_reg != bn_reg)      cmp_ord = an_reg ? ORD_LESS : ORD_GREAT;
        else if (ca_reg == cb_reg) cmp_ord = ORD_EQUAL;
        else if (cmp_lt)           cmp_ord = an_reg ? ORD_GREAT : ORD_LESS;
        else                       cmp_ord = an_reg ? ORD_LESS : ORD_GREAT;
    end

    assign s_axis_tready = (st_reg == ST_IDLE) && !vld_reg;
    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = out_reg;

    always_comb begin
        st_next   = st_reg;
        dctl.start = 1'b0;
        dvd = x_reg;
        dvs = y_reg;
        unique case (st_reg)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready && !in_nan) st_next = ST_MUL;
            ST_MUL:  if (mstep_reg == 4'd15) st_next = ST_COMB;
            ST_COMB: begin
                if (op_reg == OP_CMP) st_next = ST_OUT;
                else if (op_reg == OP_MOD) st_next = ST_MODD;
                else if (op_reg == OP_FLOOR || op_reg == OP_CEIL) st_next = ST_FLD;
                else st_next = ST_GCDD;
            end
            ST_MODD: begin dctl.start = 1'b1; st_next = ST_MODW; end
            ST_MODW: if (dsts.done) st_next = ST_GCDD;
            ST_FLD:  begin dctl.start = 1'b1; st_next = ST_FLW; end
            ST_FLW:  if (dsts.done) st_next = ST_OUT;
            ST_GCDD: begin
                if (rmag_reg == '0 || y_reg == '0) st_next = ST_RN;
                else begin dctl.start = 1'b1; st_next = ST_GCDW; end
            end
            ST_GCDW: if (dsts.done) st_next = ST_GCDD;
            ST_RN:   begin
                dvd = rmag_reg; dvs = g_reg;
                if (rmag_reg == '0) st_next = ST_OUT;
                else begin dctl.start = 1'b1; st_next = ST_RNW; end
            end
            ST_RNW:  begin
                dvd = rden_reg; dvs = g_reg;
                if (dsts.done) begin dctl.start = 1'b1; st_next = ST_RDW; end
            end
            ST_RDW:  if (dsts.done) st_next = ST_OUT;
            ST_OUT:  st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    op_reg <= in_op;
                    am_reg <= lm_w; ad_reg <= ldm_w;
                    bm_reg <= rm_w; bd_reg <= rdm_w;
                    an_reg <= (ln[WORD_BITS-1] ^ ld[WORD_BITS-1]) && ln != '0;
                    bn_reg <= (rn[WORD_BITS-1] ^ rd[WORD_BITS-1]) && rn != '0;
                    mstep_reg <= '0;
                    acc_reg <= '0;
                    // nan word, only shown when the operands call for it
                    out_reg <= {5'd0, ((in_op == OP_CMP) ? ORD_NAN : ORD_LESS), 1'b0, 1'b1,
                        31'd0, 32'd0};
                end
            end
            ST_MUL: begin
                mstep_reg <= mstep_reg + 1'b1;
                if (pi == 2'd3) begin
                    unique case (mstep_reg[3:2])
                        2'd0: ca_reg <= acc_reg + pp;
                        2'd1: cb_reg <= acc_reg + pp;
                        2'd2: cd_reg <= acc_reg + pp;
                        default: cp_reg <= acc_reg + pp;
                    endcase
                    acc_reg <= '0;
                end else begin
                    acc_reg <= acc_reg + pp;
                end
            end
            ST_COMB: begin
                // x, y = gcd seed (result mag, den) or dividend, divisor for mod/floor/ceil
                unique case (op_reg)
                    OP_ADD, OP_SUB: begin
                        rneg_reg <= sneg; rmag_reg <= smag; rden_reg <= cd_reg;
                        x_reg <= smag; y_reg <= cd_reg;
                    end
                    OP_MUL: begin
                        rneg_reg <= (an_reg != bn_reg) && cp_reg != '0; rmag_reg <= cp_reg;
                        rden_reg <= cd_reg;
                        x_reg <= cp_reg; y_reg <= cd_reg;
                    end
                    OP_DIV: begin
                        rneg_reg <= (an_reg != bn_reg) && ca_reg != '0;
                        rmag_reg <= ca_reg; rden_reg <= cb_reg;
                        x_reg <= ca_reg; y_reg <= cb_reg;
                    end
                    OP_MOD: begin
                        rneg_reg <= 1'b0; rmag_reg <= '0; rden_reg <= cd_reg;
                        x_reg <= ca_reg; y_reg <= cb_reg;
                    end
                    OP_FLOOR, OP_CEIL: begin
                        x_reg <= DW'(am_reg); y_reg <= DW'(ad_reg);
                    end
                    default: begin
                        out_reg <= {5'd0, cmp_ord, 1'b0, 1'b0, 31'd1,
                            (cmp_ord == ORD_LESS) ? 32'hFFFFFFFF :
                            (cmp_ord == ORD_EQUAL) ? 32'd0 : 32'd1};
                    end
                endcase
            end
            ST_MODW: if (dsts.done) begin
                if (dr != '0) begin
                    rneg_reg <= bn_reg;
                    rmag_reg <= (an_reg == bn_reg) ? dr : (cb_reg - dr);
                    x_reg <= (an_reg == bn_reg) ? dr : (cb_reg - dr);
                end else begin
                    rmag_reg <= '0; x_reg <= '0;
                end
                y_reg <= cd_reg;
            end
            ST_FLW: if (dsts.done) begin
                rneg_reg <= an_reg;
                rden_reg <= DW'(1);
                rmag_reg <= (dr != '0 && ((op_reg == OP_FLOOR) == an_reg)) ? dq + 1'b1 : dq;
            end
            ST_GCDD: if (rmag_reg != '0 && y_reg == '0) g_reg <= x_reg;
            ST_GCDW: if (dsts.done) begin x_reg <= y_reg; y_reg <= dr; end
            ST_RN:   if (rmag_reg == '0) begin rneg_reg <= 1'b0; rden_reg <= DW'(1); end
            ST_RNW:  if (dsts.done) rmag_reg <= dq;
            ST_RDW:  if (dsts.done) rden_reg <= dq;
            ST_OUT: begin
                if (op_reg != OP_CMP)
                    out_reg <= {5'd0, ORD_LESS, ovf, 1'b0, oden, onum};
            end
            default: ;
        endcase
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            vld_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_IDLE && s_axis_tvalid && s_axis_tready && in_nan)
                vld_reg <= 1'b1;
            else if (st_reg == ST_OUT)
                vld_reg <= 1'b1;
            else if (m_axis_tready)
                vld_reg <= 1'b0;
        end
    end

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_valid_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg |-> (st_reg == ST_IDLE)) else $error("result shown while busy");
    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        dctl.start |-> !dsts.busy || dsts.done) else $error("divider restarted");

endmodule
